### hdl/indexed_sequence_range_reduce_assert.svh
// Assertion macros for the checker file of this block.
// Both forms sample on clk and are switched off while rst_n is low.
`ifndef INDEXED_SEQUENCE_RANGE_REDUCE_ASSERT_SVH
`define INDEXED_SEQUENCE_RANGE_REDUCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/isrr_pkg.sv
`default_nettype none

package isrr_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF       = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the ports.
  localparam int OP_W    = 3;
  localparam int POS_W   = 11;
  localparam int CNT_W   = 11;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_CHANGE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_REDUCE = 3'd4
  } op_t;

  // Register select, taken from paddr bit 2 (one register every four bytes).
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  // Reduction modes.
  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_XOR = 1'b1;

  // Register reset values.
  localparam logic              MODE_RST    = MODE_SUM;
  localparam logic [DATA_W-1:0] MODULUS_RST = 32'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WRITE,
    ST_MOD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/isrr_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module isrr_ram #(
  parameter int WIDTH = isrr_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = isrr_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/indexed_sequence_range_reduce.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_op, in_position, in_range_end, in_new_value
// out      output     out_valid / out_ready  out_result_value, out_element_count, out_error
// cfg      input      APB write/read         cfg_paddr, cfg_pwdata, cfg_prdata
//
// One request is in flight at a time. Insert, erase and reduce walk the RAM one element per
// cycle through its single read and single write port. A modular range sum then runs a
// bit-serial remainder over every bit of the wide accumulator (VALUE_WIDTH capped at 32,
// plus the count width). rst_n is synchronous and holds in_ready low; the element store
// is not cleared, so the block takes a request in the first cycle after reset.
// A stalled result sits in the output register while the next beat is accepted; the
// result of that next beat then waits until the stalled one has been taken.
`default_nettype none

module indexed_sequence_range_reduce #(
  parameter int DEPTH       = isrr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = isrr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [isrr_pkg::OP_W-1:0]     in_op,
  input  wire logic [isrr_pkg::POS_W-1:0]    in_position,
  input  wire logic [isrr_pkg::POS_W-1:0]    in_range_end,
  input  wire logic [isrr_pkg::DATA_W-1:0]   in_new_value,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [isrr_pkg::DATA_W-1:0]   out_result_value,
  output logic      [isrr_pkg::CNT_W-1:0]    out_element_count,
  output logic                               out_error,

  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [isrr_pkg::PADDR_W-1:0]  cfg_paddr,
  input  wire logic [isrr_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic      [isrr_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  // Address, count and comparison widths. Stored values never exceed 32 bits
  // since they only come from the 32-bit new_value field.
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = (VALUE_WIDTH < isrr_pkg::DATA_W) ? VALUE_WIDTH : isrr_pkg::DATA_W;
  localparam int SUMW = SW + CW;
  localparam int CMPW = (CW > isrr_pkg::POS_W) ? CW : isrr_pkg::POS_W;
  localparam int BCW  = $clog2(SUMW + 1);
  localparam int MW   = isrr_pkg::DATA_W;

  // Configuration registers.
  logic          mode_r;
  logic [MW-1:0] modulus_r;

  // Control state.
  isrr_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_r, pend_nxt;

  // Per-request working registers.
  isrr_pkg::op_t    op_r, op_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [SW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    remain_r, remain_nxt;
  logic [SUMW-1:0]  acc_r, acc_nxt;
  logic [MW-1:0]    rem_r, rem_nxt;
  logic [BCW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [SW-1:0]    res_r, res_nxt;
  logic             err_r, err_nxt;

  // Output register.
  logic [MW-1:0]                  out_value_r, out_value_nxt;
  logic [isrr_pkg::CNT_W-1:0]     out_count_r, out_count_nxt;
  logic                           out_error_r, out_error_nxt;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata;

  // Request checks, evaluated against the count while idle.
  logic [CMPW-1:0] pos_x, end_x, cnt_x;
  logic            pos_below, pos_within, store_full, range_ok;
  logic [CMPW-1:0] span_ins, span_ers, span_red;

  // Compare-subtract for the bit-serial remainder.
  logic [MW:0] rem_trial, rem_reduced;

  // Configuration port: no wait states, register picked by address bit 2.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= isrr_pkg::MODE_RST;
      modulus_r <= isrr_pkg::MODULUS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        isrr_pkg::REG_MODE:    mode_r    <= cfg_pwdata[0];
        isrr_pkg::REG_MODULUS: modulus_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      isrr_pkg::REG_MODE:    cfg_prdata = {{(MW-1){1'b0}}, mode_r};
      isrr_pkg::REG_MODULUS: cfg_prdata = modulus_r;
      default:               cfg_prdata = '0;
    endcase
  end

  // Element store.
  isrr_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_isrr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Range and position checks. All compares run at a common width so that
  // positions beyond the count width are caught.
  assign pos_x      = CMPW'(in_position);
  assign end_x      = CMPW'(in_range_end);
  assign cnt_x      = CMPW'(count_r);
  assign pos_below  = pos_x < cnt_x;
  assign pos_within = pos_x <= cnt_x;
  assign store_full = count_r == CW'(DEPTH);
  assign range_ok   = (pos_x <= end_x) && (end_x <= cnt_x);
  assign span_ins   = cnt_x - pos_x;
  assign span_ers   = cnt_x - pos_x - CMPW'(1);
  assign span_red   = end_x - pos_x;

  // One restoring step: shift in the next accumulator bit, subtract the
  // modulus when it fits. The remainder stays below the modulus throughout.
  assign rem_trial   = {rem_r, acc_r[SUMW-1]};
  assign rem_reduced = (rem_trial >= {1'b0, modulus_r}) ? rem_trial - {1'b0, modulus_r}
                                                        : rem_trial;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    remain_nxt    = remain_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_error_nxt = out_error_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr_r;
    ram_wdata     = ram_rdata;

    unique case (state_r)
      isrr_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = isrr_pkg::op_t'(in_op);
          pos_nxt  = AW'(in_position);
          val_nxt  = SW'(in_new_value);
          acc_nxt  = '0;
          pend_nxt = 1'b0;
          res_nxt  = '0;
          err_nxt  = 1'b0;
          state_nxt = isrr_pkg::ST_DONE;
          unique case (in_op)
            isrr_pkg::OP_READ: begin
              if (pos_below) begin
                rd_ptr_nxt = AW'(in_position);
                remain_nxt = CW'(1);
                state_nxt  = isrr_pkg::ST_WALK;
              end else begin
                err_nxt = 1'b1;
              end
            end
            isrr_pkg::OP_CHANGE: begin
              if (pos_below) begin
                state_nxt = isrr_pkg::ST_WRITE;
              end else begin
                err_nxt = 1'b1;
              end
            end
            isrr_pkg::OP_INSERT: begin
              if (pos_within && !store_full) begin
                rd_ptr_nxt = AW'(count_r - 1'b1);
                wr_ptr_nxt = AW'(count_r);
                remain_nxt = CW'(span_ins);
                state_nxt  = isrr_pkg::ST_WALK;
              end else begin
                err_nxt = 1'b1;
              end
            end
            isrr_pkg::OP_ERASE: begin
              if (pos_below) begin
                rd_ptr_nxt = AW'(pos_x + CMPW'(1));
                wr_ptr_nxt = AW'(in_position);
                remain_nxt = CW'(span_ers);
                state_nxt  = isrr_pkg::ST_WALK;
              end else begin
                err_nxt = 1'b1;
              end
            end
            isrr_pkg::OP_REDUCE: begin
              if (range_ok) begin
                rd_ptr_nxt = AW'(in_position);
                remain_nxt = CW'(span_red);
                state_nxt  = isrr_pkg::ST_WALK;
              end else begin
                err_nxt = 1'b1;
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end

      isrr_pkg::ST_WALK: begin
        // Issue the next read; insert walks downward, everything else upward.
        if (remain_r != '0) begin
          remain_nxt = remain_r - 1'b1;
          rd_ptr_nxt = (op_r == isrr_pkg::OP_INSERT) ? rd_ptr_r - 1'b1 : rd_ptr_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        // Consume the data of the read issued last cycle.
        if (pend_r) begin
          case (op_r)
            isrr_pkg::OP_INSERT: begin
              ram_we     = 1'b1;
              wr_ptr_nxt = wr_ptr_r - 1'b1;
            end
            isrr_pkg::OP_ERASE: begin
              ram_we     = 1'b1;
              wr_ptr_nxt = wr_ptr_r + 1'b1;
            end
            isrr_pkg::OP_REDUCE: begin
              acc_nxt = (mode_r == isrr_pkg::MODE_XOR) ? acc_r ^ SUMW'(ram_rdata)
                                                       : acc_r + SUMW'(ram_rdata);
            end
            default: begin
              acc_nxt = SUMW'(ram_rdata);
            end
          endcase
        end

        if (remain_r == '0 && !pend_r) begin
          case (op_r)
            isrr_pkg::OP_INSERT: begin
              state_nxt = isrr_pkg::ST_WRITE;
            end
            isrr_pkg::OP_ERASE: begin
              count_nxt = count_r - 1'b1;
              state_nxt = isrr_pkg::ST_DONE;
            end
            isrr_pkg::OP_REDUCE: begin
              if (mode_r == isrr_pkg::MODE_SUM && modulus_r != '0) begin
                rem_nxt     = '0;
                bit_cnt_nxt = BCW'(SUMW);
                state_nxt   = isrr_pkg::ST_MOD;
              end else begin
                // XOR, or a zero modulus where the sum simply wraps.
                res_nxt   = SW'(acc_r);
                state_nxt = isrr_pkg::ST_DONE;
              end
            end
            default: begin
              res_nxt   = SW'(acc_r);
              state_nxt = isrr_pkg::ST_DONE;
            end
          endcase
        end
      end

      isrr_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        if (op_r == isrr_pkg::OP_INSERT) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = isrr_pkg::ST_DONE;
      end

      isrr_pkg::ST_MOD: begin
        if (bit_cnt_r == '0) begin
          res_nxt   = SW'(rem_r);
          state_nxt = isrr_pkg::ST_DONE;
        end else begin
          rem_nxt     = rem_reduced[MW-1:0];
          acc_nxt     = {acc_r[SUMW-2:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end

      isrr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = MW'(res_r);
          out_count_nxt = isrr_pkg::CNT_W'(count_r);
          out_error_nxt = err_r;
          state_nxt     = isrr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = isrr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isrr_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    remain_r    <= remain_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    res_r       <= res_nxt;
    err_r       <= err_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_error_r <= out_error_nxt;
  end

  // No beat is taken while reset is held, since it would be dropped.
  assign in_ready          = rst_n && (state_r == isrr_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_element_count = out_count_r;
  assign out_error         = out_error_r;

endmodule

`default_nettype wire

### hdl/isrr_checker.sv
`default_nettype none

`include "indexed_sequence_range_reduce_assert.svh"

module isrr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [isrr_pkg::DATA_W-1:0]  out_result_value,
  input wire logic [isrr_pkg::CNT_W-1:0]   out_element_count,
  input wire logic                         out_error
);

  // A stalled result beat keeps its payload.
  `ISRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_value) && $stable(out_element_count) && $stable(out_error), "result beat changed while stalled")

  // A rejected request reports a zero value.
  `ISRR_ASSERT_SAME(a_err_zero, out_valid && out_error, out_result_value == '0, "error result carries a nonzero value")

  // Only one request is worked on at a time.
  `ISRR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while a request is in flight")

  // The result of an accepted beat cannot show up in the very next cycle.
  `ISRR_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after accept")

endmodule

bind indexed_sequence_range_reduce isrr_checker u_isrr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_value  (out_result_value),
  .out_element_count (out_element_count),
  .out_error         (out_error)
);

`default_nettype wire

### tb/indexed_sequence_range_reduce_tb.sv
import isrr_pkg::*;

typedef struct packed {
  logic [DATA_W-1:0] value;
  logic [CNT_W-1:0]  count;
  logic              error;
} reply_t;

// Codes beyond the last defined request; the block must reject them.
localparam logic [OP_W-1:0] OP_UNUSED_MIN = 3'd5;
localparam logic [OP_W-1:0] OP_UNUSED_MAX = '1;

class sequence_scoreboard;
  localparam int unsigned MAX_REPORTS = 40;

  logic [DATA_W-1:0] cells [DEPTH_DEF];
  int unsigned       count;
  logic              mode;
  logic [DATA_W-1:0] modulus;
  reply_t            reply_q [$];
  int unsigned       errors;

  function new();
    count   = 0;
    mode    = MODE_RST;
    modulus = MODULUS_RST;
    errors  = 0;
  endfunction

  function void set_registers(logic new_mode, logic [DATA_W-1:0] new_modulus);
    mode    = new_mode;
    modulus = new_modulus;
  endfunction

  function int unsigned pending();
    return reply_q.size();
  endfunction

  // Sum modulo the modulus (zero meaning 2^32) or XOR over [lo, hi).
  function logic [DATA_W-1:0] range_fold(int unsigned lo, int unsigned hi);
    logic [63:0] acc;
    logic [63:0] m;
    acc = '0;
    m   = {32'd0, modulus};
    for (int unsigned i = lo; i < hi; i++) begin
      if (mode == MODE_XOR) begin
        acc = acc ^ {32'd0, cells[i]};
      end else if (modulus == '0) begin
        acc = (acc + {32'd0, cells[i]}) & 64'hFFFF_FFFF;
      end else begin
        acc = (acc + {32'd0, cells[i]} % m) % m;
      end
    end
    return acc[DATA_W-1:0];
  endfunction

  // Applies one accepted request to the shadow sequence and queues its reply.
  function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [POS_W-1:0] stop, logic [DATA_W-1:0] val);
    reply_t      r;
    int unsigned p;
    int unsigned e;
    r = '0;
    p = pos;
    e = stop;
    case (op)
      OP_READ: begin
        if (p < count) r.value = cells[p];
        else r.error = 1'b1;
      end
      OP_CHANGE: begin
        if (p < count) cells[p] = val;
        else r.error = 1'b1;
      end
      OP_INSERT: begin
        if (p <= count && count < DEPTH_DEF) begin
          for (int unsigned i = count; i > p; i--) cells[i] = cells[i-1];
          cells[p] = val;
          count++;
        end else begin
          r.error = 1'b1;
        end
      end
      OP_ERASE: begin
        if (p < count) begin
          for (int unsigned i = p; i + 1 < count; i++) cells[i] = cells[i+1];
          count--;
        end else begin
          r.error = 1'b1;
        end
      end
      OP_REDUCE: begin
        if (p <= e && e <= count) r.value = range_fold(p, e);
        else r.error = 1'b1;
      end
      default: r.error = 1'b1;
    endcase
    r.count = CNT_W'(count);
    reply_q.push_back(r);
  endfunction

  function void mismatch(string what, logic [DATA_W-1:0] exp_val, logic [DATA_W-1:0] act_val);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_val, act_val);
  endfunction

  function void check_reply(logic [DATA_W-1:0] value, logic [CNT_W-1:0] cnt, logic err);
    reply_t exp_r;
    if (reply_q.size() == 0) begin
      mismatch("unrequested result, value", '0, value);
      return;
    end
    exp_r = reply_q.pop_front();
    if (exp_r.value !== value) mismatch("result_value", exp_r.value, value);
    if (exp_r.count !== cnt)   mismatch("element_count", DATA_W'(exp_r.count), DATA_W'(cnt));
    if (exp_r.error !== err)   mismatch("error", DATA_W'(exp_r.error), DATA_W'(err));
  endfunction
endclass

module indexed_sequence_range_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run holds about 580 requests. None may take longer than a walk over
  // the full store plus the bit-serial remainder, plus the random gaps on
  // both sides; the limit is well over ten times that bound.
  localparam int unsigned LIMIT_CYCLES = 10_000_000;
  // Cycles allowed after the last reply for a stray beat to show up: one full
  // walk of the store and the remainder pass.
  localparam int unsigned TAIL_CYCLES = 1200;
  localparam int unsigned PHASE_ITEMS = 69;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [POS_W-1:0]  in_range_end = '0;
  logic [DATA_W-1:0] in_new_value = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic [CNT_W-1:0]  out_element_count;
  logic              out_error;

  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Chance in a hundred that the sender idles, or the receiver stalls, in a
  // given cycle. The main sequence changes both from phase to phase.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;

  sequence_scoreboard sb;

  indexed_sequence_range_reduce DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_range_end     (in_range_end),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_element_count(out_element_count),
    .out_error        (out_error),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #5 clk = ~clk;

  // The receiver drops ready at random; with stall_pct at zero it never does.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every result beat is checked against the oldest outstanding reply. All
  // signals read here were last changed by nonblocking assignments, so the
  // values seen are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply(out_result_value, out_element_count, out_error);
  end

  // A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one request beat, possibly after a random idle gap, and holds it
  // until the block takes it. The shadow sequence is updated at the accepting
  // edge, so the next request is chosen against the up-to-date count. The task
  // returns in the step of that edge; the caller's next assignment to in_valid
  // is then the only one in that step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [POS_W-1:0] stop, input logic [DATA_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_position  <= pos;
    in_range_end <= stop;
    in_new_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.apply_request(op, pos, stop, val);
  endtask

  // Holds off the sender until every outstanding reply has come back. Since
  // each request yields exactly one reply, the block is idle afterwards.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Writes the mode register and then the modulus register as two
  // back-to-back transfers; psel stays high between them.
  task automatic apply_config(input logic mode, input logic [DATA_W-1:0] modulus_val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_MODE, 2'b00};
    cfg_pwdata  <= {{(DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_MODULUS, 2'b00};
    cfg_pwdata  <= modulus_val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_registers(mode, modulus_val);
  endtask

  // Values lean on zero, all ones and small numbers, which stress the sums.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return DATA_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current count, which is steered
  // to stay below a few dozen so that walks stay short. About one in eight is
  // malformed: unknown codes, raw field values, backward or overlong ranges,
  // and positions just past the end.
  task automatic send_random_request();
    int unsigned      n;
    int unsigned      pick;
    int unsigned      grow;
    int unsigned      shrink;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] stop;
    n    = sb.count;
    pick = $urandom_range(99);
    // range_end only matters to a reduce; elsewhere it carries random bits.
    stop = POS_W'($urandom);
    if (pick < 12) begin
      case ($urandom_range(5))
        0: begin
          op  = OP_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
          pos = POS_W'($urandom);
        end
        1: begin
          op  = OP_W'($urandom);
          pos = POS_W'($urandom);
        end
        2: begin
          // Start beyond the end.
          op   = OP_REDUCE;
          pos  = POS_W'((n == 0) ? 1 : $urandom_range(1, n));
          stop = POS_W'($urandom_range(0, pos - 1));
        end
        3: begin
          // End beyond the count.
          op   = OP_REDUCE;
          pos  = POS_W'($urandom_range(0, n));
          stop = POS_W'(n + 1 + $urandom_range(0, 3));
        end
        4: begin
          case ($urandom_range(2))
            0: op = OP_READ;
            1: op = OP_CHANGE;
            default: op = OP_ERASE;
          endcase
          pos = POS_W'(n + $urandom_range(0, 2));
        end
        default: begin
          op  = OP_INSERT;
          pos = POS_W'(n + 1 + $urandom_range(0, 3));
        end
      endcase
    end else begin
      grow   = (n < 4) ? 60 : (n > 40) ? 5 : 25;
      shrink = (n > 40) ? 45 : 15;
      pick   = $urandom_range(99);
      if (n == 0 || pick < grow) begin
        op  = OP_INSERT;
        pos = POS_W'($urandom_range(0, n));
      end else if (pick < grow + shrink) begin
        op  = OP_ERASE;
        pos = POS_W'($urandom_range(0, n - 1));
      end else begin
        case ($urandom_range(2))
          0: begin
            op  = OP_READ;
            pos = POS_W'($urandom_range(0, n - 1));
          end
          1: begin
            op  = OP_CHANGE;
            pos = POS_W'($urandom_range(0, n - 1));
          end
          default: begin
            op = OP_REDUCE;
            if ($urandom_range(3) == 0) begin
              pos  = '0;
              stop = POS_W'(n);
            end else begin
              pos  = POS_W'($urandom_range(0, n));
              stop = POS_W'($urandom_range(pos, n));
            end
          end
        endcase
      end
    end
    send_request(op, pos, stop, pick_value());
  endtask

  initial begin
    logic              mode;
    logic [DATA_W-1:0] modulus_val;
    int unsigned       n;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset settings (range sums modulo three).
    // Everything on an empty store is rejected except the empty range.
    send_request(OP_READ,   0, 0, '0);
    send_request(OP_ERASE,  0, 0, '0);
    send_request(OP_CHANGE, 0, 0, '1);
    send_request(OP_REDUCE, 0, 0, '0);
    send_request(OP_INSERT, 1, 0, '1);
    // Build four elements with a first insert, an append, a front insert and
    // a middle insert.
    send_request(OP_INSERT, 0, 0, '1);
    send_request(OP_INSERT, 1, 0, '0);
    send_request(OP_INSERT, 0, 0, 32'h1234_5678);
    send_request(OP_INSERT, 1, 0, 32'h8000_0001);
    send_request(OP_READ,   3, 0, '0);
    send_request(OP_READ,   4, 0, '0);
    send_request(OP_CHANGE, 3, 0, 32'd5);
    send_request(OP_REDUCE, 0, 4, '0);
    send_request(OP_REDUCE, 1, 3, '0);
    send_request(OP_REDUCE, 3, 2, '0);
    send_request(OP_REDUCE, 0, 5, '0);
    send_request(OP_REDUCE, 4, 4, '0);
    send_request(OP_ERASE,  0, 0, '0);
    send_request(OP_ERASE,  3, 0, '0);
    send_request(OP_UNUSED_MIN, 0, 0, '0);
    send_request(OP_UNUSED_MAX, '1, '1, '1);
    send_request(OP_READ,   '1, '1, '0);
    send_request(OP_REDUCE, 0, '1, '0);
    send_request(OP_INSERT, POS_W'(DEPTH_DEF), 0, '1);
    send_request(OP_ERASE,  2, 0, '0);

    // Random phases. Each one starts from an idle block with new register
    // values and its own mix of sender gaps and receiver stalls.
    for (int p = 0; p < 8; p++) begin
      wait_for_replies();
      case (p)
        0: begin mode = MODE_SUM; modulus_val = MODULUS_RST;  end
        1: begin mode = MODE_SUM; modulus_val = 32'd1;        end
        2: begin mode = MODE_SUM; modulus_val = '0;           end
        3: begin mode = MODE_XOR; modulus_val = $urandom;     end
        4: begin mode = MODE_SUM; modulus_val = '1;           end
        5: begin mode = MODE_SUM; modulus_val = $urandom_range(2, 1000); end
        6: begin mode = MODE_SUM; modulus_val = $urandom;     end
        default: begin mode = MODE_XOR; modulus_val = $urandom; end
      endcase
      apply_config(mode, modulus_val);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        send_random_request();
        // Now and then the sender waits for the block to drain completely.
        if ($urandom_range(39) == 0) wait_for_replies();
      end
    end

    // Whole-sequence reductions under the other settings: the sum wraps at 32
    // bits with a zero modulus and collapses to zero with a modulus of one.
    wait_for_replies();
    n = sb.count;
    apply_config(MODE_SUM, '0);
    send_request(OP_REDUCE, 0, POS_W'(n), '0);
    wait_for_replies();
    apply_config(MODE_XOR, 32'd7);
    send_request(OP_REDUCE, 0, POS_W'(n), '0);
    wait_for_replies();
    apply_config(MODE_SUM, 32'd1);
    send_request(OP_REDUCE, 0, POS_W'(n), '0);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
